[src/fasp_pkg.sv]
// ----------------------------------------------------------------------------
// fasp_pkg: shared types for the four-axis stepper positioner
// Operation codes, item payload structs and the per-axis command struct.
// ----------------------------------------------------------------------------
package fasp_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_ABS  = 2'd1,
    OP_SET_REL  = 2'd2,
    OP_SET_POS  = 2'd3
  } op_t;

  // Input item
  typedef struct packed {
    op_t                op;
    logic [1:0]         axis;
    logic signed [31:0] value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0]         step_pins;
    logic signed [31:0] axis_position;
    logic signed [31:0] axis_target;
    logic [3:0]         moving_mask;
  } out_item_t;

  // Command to one axis for the item being accepted
  typedef struct packed {
    logic en;        // item accepted this cycle
    logic step;      // step update on this tick
    logic set_goal;  // load absolute target
    logic add_goal;  // load target relative to position
    logic set_pos;   // load position and target
  } axis_cmd_t;

endpackage

[src/fasp_axis.sv]
// ----------------------------------------------------------------------------
// fasp_axis: position and target of one stepper axis
// Holds the axis state, applies set commands and step updates, and exposes
// the state as it stands after the current item.
// ----------------------------------------------------------------------------
module fasp_axis
  import fasp_pkg::*;
#(
  parameter int POS_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  axis_cmd_t            cmd,
  input  logic [POS_WIDTH-1:0] value,
  output logic [POS_WIDTH-1:0] pos_next,
  output logic [POS_WIDTH-1:0] goal_next,
  output logic [1:0]           pins,
  output logic                 moving
);

  logic [POS_WIDTH-1:0] pos;
  logic [POS_WIDTH-1:0] goal;

  // Next state for this item
  always_comb begin
    pos_next  = pos;
    goal_next = goal;
    pins      = 2'b00;
    if (cmd.step) begin
      if ($signed(pos) < $signed(goal)) begin
        pins     = 2'b11;
        pos_next = pos + POS_WIDTH'(1);
      end else if ($signed(pos) > $signed(goal)) begin
        pins     = 2'b10;
        pos_next = pos - POS_WIDTH'(1);
      end
    end else if (cmd.set_goal) begin
      goal_next = value;
    end else if (cmd.add_goal) begin
      goal_next = value + pos;
    end else if (cmd.set_pos) begin
      pos_next  = value;
      goal_next = value;
    end
  end

  assign moving = (pos_next != goal_next);

  // State update on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      goal <= '0;
    end else if (cmd.en) begin
      pos  <= pos_next;
      goal <= goal_next;
    end
  end

endmodule

[src/four_axis_stepper_positioner.sv]
// ----------------------------------------------------------------------------
// four_axis_stepper_positioner: step/direction generator for stepper axes
// Keeps position and target per axis and steps all axes toward their targets
// every step_period ticks.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one item: op, axis, value. op is a 1 ms tick or a
//   set of absolute target, relative target or position on the given axis.
//   out_valid/out_stall carry one result per item: step and direction pins,
//   position and target of the addressed axis, and the mask of moving axes.
//   The result of an accepted item is registered in the output register, or in
//   the skid register while the output is stalled. Throughput is one item per
//   cycle while in_stall is low; all axes compare and step in parallel.
//   The result side has an output register plus a skid register; in_stall is
//   the registered skid-full flag, so a stall on the result side reaches the
//   input through that register and no item is lost.
//   step_period is written through cfg_wr_en/cfg_wr_data; the user must write
//   it only while idle, which the block does not enforce. Zero acts as one.
//   Synchronous reset clears all positions, targets and the tick count, sets
//   step_period to one and empties both output registers.
// ----------------------------------------------------------------------------
module four_axis_stepper_positioner
  import fasp_pkg::*;
#(
  parameter int AXES      = 4,
  parameter int POS_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  logic [15:0] step_period;
  logic [15:0] tick_count;
  logic [15:0] tick_count_next;
  logic [15:0] period_eff;
  logic        fire;
  logic        accept;
  logic        is_tick;
  logic        axis_ok;
  logic [POS_WIDTH-1:0] value_ext;

  logic [POS_WIDTH-1:0] pos_next  [AXES];
  logic [POS_WIDTH-1:0] goal_next [AXES];
  logic [2*AXES-1:0]    pins;
  logic [AXES-1:0]      moving;
  axis_cmd_t            cmd       [AXES];

  out_item_t result;
  logic      skid_valid;
  out_item_t skid_item;

  assign accept    = in_valid && !skid_valid;
  assign in_stall  = skid_valid;
  assign is_tick   = (in_item.op == OP_TICK);
  assign axis_ok   = (int'(in_item.axis) < AXES);
  assign value_ext = POS_WIDTH'(in_item.value);

  // Tick divider
  assign period_eff      = (step_period == '0) ? 16'd1 : step_period;
  assign tick_count_next = tick_count + 16'd1;
  assign fire            = (tick_count_next >= period_eff) || (tick_count_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      step_period <= 16'd1;
    end else begin
      if (cfg_wr_en) begin
        step_period <= cfg_wr_data;
      end
      if (accept && is_tick) begin
        tick_count <= fire ? '0 : tick_count_next;
      end
    end
  end

  // Axis lanes
  for (genvar j = 0; j < AXES; j++) begin : g_axis
    logic sel;
    assign sel             = axis_ok && (int'(in_item.axis) == j);
    assign cmd[j].en       = accept;
    assign cmd[j].step     = is_tick && fire;
    assign cmd[j].set_goal = sel && (in_item.op == OP_SET_ABS);
    assign cmd[j].add_goal = sel && (in_item.op == OP_SET_REL);
    assign cmd[j].set_pos  = sel && (in_item.op == OP_SET_POS);

    fasp_axis #(
      .POS_WIDTH(POS_WIDTH)
    ) u_axis (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd[j]),
      .value    (value_ext),
      .pos_next (pos_next[j]),
      .goal_next(goal_next[j]),
      .pins     (pins[2*j +: 2]),
      .moving   (moving[j])
    );
  end

  // Result fields; pin and mask bits beyond the field widths are dropped
  always_comb begin
    result.step_pins     = 8'(pins);
    result.moving_mask   = 4'(moving);
    result.axis_position = '0;
    result.axis_target   = '0;
    for (int j = 0; j < AXES; j++) begin
      if (int'(in_item.axis) == j) begin
        result.axis_position = 32'(pos_next[j]);
        result.axis_target   = 32'(goal_next[j]);
      end
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (accept) begin
        out_item <= result;
      end
    end else if (accept) begin
      skid_item <= result;
    end
  end

endmodule

[sim/four_axis_stepper_positioner_test.sv]
// ----------------------------------------------------------------------------
// four_axis_stepper_positioner_test: self-checking bench for the positioner
// Drives ticks and target/position commands with random handshake gaps,
// predicts every report from a local copy of the axis state, and compares
// each report field by field in order.
// ----------------------------------------------------------------------------
import fasp_pkg::*;

// Predicts reports of the positioner and checks them in order
class positioner_scoreboard;
  logic signed [31:0] pos [4];
  logic signed [31:0] goal [4];
  logic [15:0]        tick_cnt;
  logic [15:0]        period;
  out_item_t          pending_reports [$];
  int                 errors;
  int                 reports_checked;
  int                 step_reports;
  int                 pin_seen;

  function void reset_state();
    for (int j = 0; j < 4; j++) begin
      pos[j]  = '0;
      goal[j] = '0;
    end
    tick_cnt = '0;
    period   = 16'd1;
    pending_reports.delete();
  endfunction

  function void set_period(logic [15:0] p);
    period = p;
  endfunction

  // Apply one accepted command and queue the report it causes
  function void note_command(in_item_t cmd);
    out_item_t   rep;
    logic [15:0] eff;
    int          a;
    rep = '0;
    a   = cmd.axis;
    case (cmd.op)
      OP_TICK: begin
        eff      = (period == 16'd0) ? 16'd1 : period;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= eff || tick_cnt == 16'd0) begin
          tick_cnt = '0;
          for (int j = 0; j < 4; j++) begin
            if (pos[j] < goal[j]) begin
              rep.step_pins[2*j +: 2] = 2'b11;
              pos[j] = pos[j] + 32'sd1;
            end else if (pos[j] > goal[j]) begin
              rep.step_pins[2*j +: 2] = 2'b10;
              pos[j] = pos[j] - 32'sd1;
            end
          end
        end
      end
      OP_SET_ABS: goal[a] = cmd.value;
      OP_SET_REL: goal[a] = cmd.value + pos[a];
      OP_SET_POS: begin
        pos[a]  = cmd.value;
        goal[a] = cmd.value;
      end
      default: ;
    endcase
    rep.axis_position = pos[a];
    rep.axis_target   = goal[a];
    for (int j = 0; j < 4; j++) rep.moving_mask[j] = (pos[j] != goal[j]);
    pending_reports.push_back(rep);
  endfunction

  function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, got_v);
    end
  endfunction

  // Check one report against the oldest prediction
  function void check_report(out_item_t got);
    out_item_t exp_r;
    if (pending_reports.size() == 0) begin
      errors++;
      $display("%0t: report with nothing pending, expected none actual %h", $time, got);
      return;
    end
    exp_r = pending_reports.pop_front();
    reports_checked++;
    if (exp_r.step_pins != 0) step_reports++;
    pin_seen |= got.step_pins;
    compare_field("step_pins", exp_r.step_pins, got.step_pins);
    compare_field("axis_position", exp_r.axis_position, got.axis_position);
    compare_field("axis_target", exp_r.axis_target, got.axis_target);
    compare_field("moving_mask", exp_r.moving_mask, got.moving_mask);
  endfunction
endclass

module four_axis_stepper_positioner_test;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 80;
  localparam int PHASE_ITEMS = 85;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;

  positioner_scoreboard sb = new();

  int cycles;
  int items_sent;
  int rx_wait_left;
  bit rx_burst;
  bit tx_burst;
  bit hold_off_req;
  bit force_no_gap;

  four_axis_stepper_positioner u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycles,
               sb.pending_reports.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Report monitor: check each accepted report, draw the next stall length
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_report(out_item);
      if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
      rx_wait_left = rx_burst ? 0 : $urandom_range(0, 14);
    end
  end

  // Report sink: stall per drawn wait, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      out_stall <= (rx_wait_left > 0);
      if (rx_wait_left > 0) rx_wait_left--;
    end
  end

  // Offer one command after a gap and hold it until accepted
  task automatic send_cmd(in_item_t cmd);
    int gap;
    if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
    gap = (tx_burst || force_no_gap) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= cmd;
    do @(posedge clk); while (in_stall);
    sb.note_command(cmd);
    items_sent++;
  endtask

  task automatic send_op(op_t op, logic [1:0] axis, logic [31:0] value);
    in_item_t cmd;
    cmd.op    = op;
    cmd.axis  = axis;
    cmd.value = value;
    send_cmd(cmd);
  endtask

  // Drop valid and wait until every report is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write step_period while idle
  task automatic write_period(logic [15:0] p);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    sb.set_period(p);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly reachable targets near the current position, some far-off noise
  function automatic in_item_t random_cmd();
    in_item_t cmd;
    int       r;
    cmd.axis  = $urandom_range(0, 3);
    cmd.value = $urandom();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      cmd.op = OP_TICK;
    end else if (r < 65) begin
      cmd.op    = OP_SET_ABS;
      cmd.value = sb.pos[cmd.axis] + $signed($urandom_range(0, 40)) - 32'sd20;
    end else if (r < 80) begin
      cmd.op    = OP_SET_REL;
      cmd.value = $signed($urandom_range(0, 40)) - 32'sd20;
    end else if (r < 88) begin
      cmd.op = OP_SET_POS;
      case ($urandom_range(0, 2))
        0: cmd.value = 32'h7FFF_FFFF - $urandom_range(0, 8);
        1: cmd.value = 32'h8000_0000 + $urandom_range(0, 8);
        default: ;
      endcase
    end else if (r < 94) begin
      cmd.op = OP_SET_ABS;
    end else begin
      cmd.op = OP_SET_REL;
    end
    return cmd;
  endfunction

  // Main sequence
  initial begin
    logic [15:0] periods [6];
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_item      = '0;
    rx_wait_left = 0;
    sb.reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes near both ends of the range, every operation
    send_op(OP_TICK, 2'd0, 32'h0);
    send_op(OP_SET_POS, 2'd0, 32'h7FFF_FFFD);
    send_op(OP_SET_ABS, 2'd0, 32'h7FFF_FFFF);
    send_op(OP_SET_POS, 2'd1, 32'h8000_0002);
    send_op(OP_SET_ABS, 2'd1, 32'h8000_0000);
    send_op(OP_SET_REL, 2'd2, 32'h0000_0003);
    send_op(OP_SET_REL, 2'd3, 32'hFFFF_FFFE);
    // value and axis on a tick only pick the reported axis
    send_op(OP_TICK, 2'd1, 32'hFFFF_FFFF);
    send_op(OP_TICK, 2'd2, 32'h5555_AAAA);
    send_op(OP_TICK, 2'd3, 32'hAAAA_5555);
    // relative target wrapping past the top of the range
    send_op(OP_SET_REL, 2'd0, 32'h0000_0001);
    send_op(OP_TICK, 2'd0, 32'h0);
    send_op(OP_SET_POS, 2'd3, 32'h0);
    send_op(OP_SET_ABS, 2'd2, 32'hFFFF_FFFF);

    // Zero period behaves as one
    write_period(16'd0);
    send_op(OP_TICK, 2'd2, 32'h0);
    send_op(OP_TICK, 2'd1, 32'h0);

    // Period lowered below the running count steps on the next tick
    write_period(16'd5);
    send_op(OP_SET_ABS, 2'd3, 32'h0000_0010);
    send_op(OP_TICK, 2'd3, 32'h0);
    send_op(OP_TICK, 2'd3, 32'h0);
    send_op(OP_TICK, 2'd3, 32'h0);
    write_period(16'd2);
    send_op(OP_TICK, 2'd3, 32'h0);
    send_op(OP_TICK, 2'd3, 32'h0);

    // Random phases over several periods, extremes included
    periods[0] = 16'd1;
    periods[1] = 16'd3;
    periods[2] = 16'd0;
    periods[3] = 16'd65535;
    periods[4] = 16'd2;
    periods[5] = 16'd1;
    for (int ph = 0; ph < 6; ph++) begin
      write_period(periods[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // one long receiver hold-off while items keep coming back to back
        if (ph == 1 && n == 10) begin
          hold_off_req = 1'b1;
          force_no_gap = 1'b1;
        end
        if (ph == 1 && n == 40) force_no_gap = 1'b0;
        send_cmd(random_cmd());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending_reports.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d reports never arrived", $time, sb.pending_reports.size());
    end
    $display("ran %0d commands over periods 0, 1, 2, 3, 5 and 65535 with random gaps",
             items_sent);
    $display("checked %0d reports, %0d with steps, pin bits seen %b",
             sb.reports_checked, sb.step_reports, sb.pin_seen[7:0]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
src/fasp_pkg.sv
src/fasp_axis.sv
src/four_axis_stepper_positioner.sv
sim/four_axis_stepper_positioner_test.sv
